// File: rtl/core/r2h_pkg.sv
// Shared types and constants for the RGB to HSV conversion core.
// Depends on nothing; every other file of the core uses it by scoped names.
package r2h_pkg;

   // Number of quotient bits produced by the divider chain, one per cell.
   localparam int QuoBits = 16;
   // Remainder widths: the saturation divisor is the 8-bit maximum, the hue
   // divisor is six times an 8-bit delta.
   localparam int SatRemBits = 8;
   localparam int HueRemBits = 11;

   // One input word: an RGB pixel with 8 bits per channel.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } r2h_pixel_type;

   // One result word: hue, saturation and value.
   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] saturation;
      logic [7:0]  brightness;
   } r2h_hsv_type;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic                  valid;
      logic                  gray;
      logic [7:0]            bright;
      logic [SatRemBits-1:0] sat_rem;
      logic [SatRemBits-1:0] sat_den;
      logic [QuoBits-1:0]    sat_num;
      logic [QuoBits-1:0]    sat_quo;
      logic [HueRemBits-1:0] hue_rem;
      logic [HueRemBits-1:0] hue_den;
      logic [QuoBits-1:0]    hue_quo;
   } r2h_lane_type;

endpackage

// File: rtl/core/r2h_prep.sv
// Front stage of the conversion core: max, min, delta, hue sector position
// and the saturation numerator, registered. Depends on r2h_pkg.
module r2h_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  r2h_pkg::r2h_pixel_type in_pixel,
   output r2h_pkg::r2h_lane_type  lane_ff
);

   r2h_pkg::r2h_lane_type lane_in;
   logic [7:0]  r, g, b, mx, mn, delta;
   logic        red_top, green_top;
   logic [11:0] d2, d4, d6, pos;
   logic [23:0] sat_numer;

   always_comb begin
      r = in_pixel.red;
      g = in_pixel.green;
      b = in_pixel.blue;
      // Largest channel, red winning ties over green, green over blue.
      red_top   = (r >= g) && (r >= b);
      green_top = !red_top && (g >= b);
      mx = red_top ? r : (green_top ? g : b);
      mn = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
      delta = mx - mn;
      d2 = {3'b000, delta, 1'b0};
      d4 = {2'b00, delta, 2'b00};
      d6 = d2 + d4;
      // Position within the turn in units of 1/(6*delta), already wrapped
      // into the range below one turn.
      if (red_top) begin
         pos = (g >= b) ? ({4'b0000, g} - {4'b0000, b})
                        : (d6 + {4'b0000, g} - {4'b0000, b});
      end else if (green_top) begin
         pos = d2 + {4'b0000, b} - {4'b0000, r};
      end else begin
         pos = d4 + {4'b0000, r} - {4'b0000, g};
      end
      // delta * 65535 without a multiplier.
      sat_numer = {delta, 16'h0000} - {16'h0000, delta};

      lane_in.valid   = in_valid;
      lane_in.gray    = (delta == 8'd0);
      lane_in.bright  = mx;
      lane_in.sat_rem = sat_numer[23:16];
      lane_in.sat_den = mx;
      lane_in.sat_num = sat_numer[15:0];
      lane_in.sat_quo = '0;
      lane_in.hue_rem = pos[r2h_pkg::HueRemBits-1:0];
      lane_in.hue_den = d6[r2h_pkg::HueRemBits-1:0];
      lane_in.hue_quo = '0;
   end

   // Stage register; only the valid bit is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff.valid <= lane_in.valid;
      end
      if (advance) begin
         lane_ff.gray    <= lane_in.gray;
         lane_ff.bright  <= lane_in.bright;
         lane_ff.sat_rem <= lane_in.sat_rem;
         lane_ff.sat_den <= lane_in.sat_den;
         lane_ff.sat_num <= lane_in.sat_num;
         lane_ff.sat_quo <= lane_in.sat_quo;
         lane_ff.hue_rem <= lane_in.hue_rem;
         lane_ff.hue_den <= lane_in.hue_den;
         lane_ff.hue_quo <= lane_in.hue_quo;
      end
   end

endmodule

// File: rtl/core/r2h_cell.sv
// One divider cell: a restoring step for both the saturation and the hue
// quotient, one quotient bit each, registered. Depends on r2h_pkg.
module r2h_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  r2h_pkg::r2h_lane_type lane_prev,
   output r2h_pkg::r2h_lane_type lane_ff
);

   r2h_pkg::r2h_lane_type lane_in;
   logic [r2h_pkg::SatRemBits:0] sat_try;
   logic [r2h_pkg::HueRemBits:0] hue_try;
   logic                         sat_bit, hue_bit;

   always_comb begin
      lane_in = lane_prev;
      // Saturation: bring in the next numerator bit and try to subtract.
      sat_try = {lane_prev.sat_rem, lane_prev.sat_num[r2h_pkg::QuoBits-1]};
      sat_bit = (sat_try >= {1'b0, lane_prev.sat_den});
      lane_in.sat_rem = sat_bit ? r2h_pkg::SatRemBits'(sat_try - {1'b0, lane_prev.sat_den})
                                : sat_try[r2h_pkg::SatRemBits-1:0];
      lane_in.sat_num = {lane_prev.sat_num[r2h_pkg::QuoBits-2:0], 1'b0};
      lane_in.sat_quo = {lane_prev.sat_quo[r2h_pkg::QuoBits-2:0], sat_bit};
      // Hue: the numerator continues with zeros.
      hue_try = {lane_prev.hue_rem, 1'b0};
      hue_bit = (hue_try >= {1'b0, lane_prev.hue_den});
      lane_in.hue_rem = hue_bit ? r2h_pkg::HueRemBits'(hue_try - {1'b0, lane_prev.hue_den})
                                : hue_try[r2h_pkg::HueRemBits-1:0];
      lane_in.hue_quo = {lane_prev.hue_quo[r2h_pkg::QuoBits-2:0], hue_bit};
   end

   // Cell register; only the valid bit is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff.valid <= lane_in.valid;
      end
      if (advance) begin
         lane_ff.gray    <= lane_in.gray;
         lane_ff.bright  <= lane_in.bright;
         lane_ff.sat_rem <= lane_in.sat_rem;
         lane_ff.sat_den <= lane_in.sat_den;
         lane_ff.sat_num <= lane_in.sat_num;
         lane_ff.sat_quo <= lane_in.sat_quo;
         lane_ff.hue_rem <= lane_in.hue_rem;
         lane_ff.hue_den <= lane_in.hue_den;
         lane_ff.hue_quo <= lane_in.hue_quo;
      end
   end

endmodule

// File: rtl/core/rgb_to_hsv_convert_core.sv
// Top level of the RGB to HSV conversion core: front stage and a row of
// divider cells. Depends on r2h_pkg, r2h_prep and r2h_cell.
//
//   channel | ports                          | word
//   input   | req_valid, req_stall, req_data | r2h_pixel_type
//   result  | rsp_valid, rsp_stall, rsp_data | r2h_hsv_type
//
// One pixel is accepted per cycle while the row is not stalled. The path is 17 registers
// deep, one front stage and one divider cell per quotient bit (16).
// Reset clears the valid bits of every stage; the data registers are not reset.
// A stalled result holds the whole row, and req_stall follows it in the same cycle.
module rgb_to_hsv_convert_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  r2h_pkg::r2h_pixel_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output r2h_pkg::r2h_hsv_type   rsp_data
);

   r2h_pkg::r2h_lane_type lane [0:r2h_pkg::QuoBits];
   logic                  advance;

   // The row moves unless a finished word is held at the output.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   r2h_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_pixel (req_data),
      .lane_ff  (lane[0])
   );

   // One cell per quotient bit.
   for (genvar i = 0; i < r2h_pkg::QuoBits; i++) begin : g_cell
      r2h_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .lane_prev (lane[i]),
         .lane_ff   (lane[i+1])
      );
   end

   // Gray pixels give zero hue and zero saturation.
   assign rsp_valid           = lane[r2h_pkg::QuoBits].valid;
   assign rsp_data.hue        = lane[r2h_pkg::QuoBits].gray ? 16'h0000
                                                            : lane[r2h_pkg::QuoBits].hue_quo;
   assign rsp_data.saturation = lane[r2h_pkg::QuoBits].gray ? 16'h0000
                                                            : lane[r2h_pkg::QuoBits].sat_quo;
   assign rsp_data.brightness = lane[r2h_pkg::QuoBits].bright;

endmodule

// File: rtl/core/r2h_checker.sv
// Port-level checks for the RGB to HSV conversion core, bound to the top level.
// Depends on r2h_pkg and rgb_to_hsv_convert_core.
module r2h_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input r2h_pkg::r2h_hsv_type rsp_data
);

   // A stalled result word stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // The input is held back exactly when a result word is held.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

   // Black pixels have no saturation.
   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.brightness == 8'd0 |-> rsp_data.saturation == 16'h0000)
      else $error("black pixel with nonzero saturation");

   // Zero saturation means a gray pixel, whose hue is zero.
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturation == 16'h0000 |-> rsp_data.hue == 16'h0000)
      else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_convert_core r2h_checker u_r2h_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for rgb_to_hsv_convert_core: drives pixels, predicts each HSV word
// and checks results in order. Depends on r2h_pkg and the core RTL.
module tb_top;

   // Scoreboard that predicts HSV words and keeps them in arrival order.
   class hsv_scoreboard;
      r2h_pkg::r2h_hsv_type pending_hsv[$];
      int unsigned errors;

      function r2h_pkg::r2h_hsv_type convert_pixel(r2h_pkg::r2h_pixel_type px);
         r2h_pkg::r2h_hsv_type res;
         int mx;
         int mn;
         int delta;
         longint pos;
         longint quo;
         mx = px.red;
         if (px.green > mx) mx = px.green;
         if (px.blue > mx) mx = px.blue;
         mn = px.red;
         if (px.green < mn) mn = px.green;
         if (px.blue < mn) mn = px.blue;
         delta = mx - mn;
         res = '0;
         res.brightness = mx[7:0];
         if (delta != 0) begin
            res.saturation = 16'((longint'(delta) * 65535) / mx);
            // Red wins ties over green, green over blue.
            if (px.red == mx) begin
               pos = longint'(px.green) - px.blue;
            end else if (px.green == mx) begin
               pos = 2 * delta + longint'(px.blue) - px.red;
            end else begin
               pos = 4 * delta + longint'(px.red) - px.green;
            end
            // Add a full turn so the floor never sees a negative value.
            pos = pos + 6 * delta;
            quo = (pos * 65536) / (6 * delta);
            res.hue = quo[15:0];
         end
         return res;
      endfunction

      function void note_pixel(r2h_pkg::r2h_pixel_type px);
         pending_hsv.push_back(convert_pixel(px));
      endfunction

      function void check_hsv(r2h_pkg::r2h_hsv_type got);
         r2h_pkg::r2h_hsv_type want;
         if (pending_hsv.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            errors++;
            return;
         end
         want = pending_hsv.pop_front();
         if (got.hue !== want.hue) begin
            $error("hue expected %0d actual %0d", want.hue, got.hue);
            errors++;
         end
         if (got.saturation !== want.saturation) begin
            $error("saturation expected %0d actual %0d", want.saturation, got.saturation);
            errors++;
         end
         if (got.brightness !== want.brightness) begin
            $error("brightness expected %0d actual %0d", want.brightness, got.brightness);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   r2h_pkg::r2h_pixel_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   r2h_pkg::r2h_hsv_type   rsp_data;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   hsv_scoreboard hsv_board = new();

   always #2 clock = ~clock;

   rgb_to_hsv_convert_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Check each accepted result word at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) hsv_board.check_hsv(rsp_data);
   end

   // Random receiver stalls, changed at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Drive one pixel word and hold it until accepted, with random idle gaps.
   // The valid line stays high after acceptance so the next word can follow at once.
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      r2h_pkg::r2h_pixel_type px;
      px.red = r;
      px.green = g;
      px.blue = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hsv_board.note_pixel(px);
      @(negedge clock);
   endtask

   // Random pixel, often with ties or a gray value to reach the edge cases.
   task automatic send_random_pixel();
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      int unsigned mode;
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      mode = $urandom_range(9);
      if (mode == 0) begin
         g = r;
         b = r;
      end else if (mode == 1) begin
         g = r;
      end else if (mode == 2) begin
         b = g;
      end else if (mode == 3) begin
         b = r;
      end else if (mode == 4) begin
         // Small delta stresses the hue divider.
         g = r + 8'($urandom_range(2));
         b = r - 8'($urandom_range(2));
      end
      send_pixel(r, g, b);
   endtask

   initial begin
      #400000;
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      int unsigned wait_cycles;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words: extremes, gray, each sector, ties and wrap.
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd254, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd1, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd100, 8'd50);
      send_pixel(8'd50, 8'd200, 8'd100);
      send_pixel(8'd100, 8'd50, 8'd200);
      send_pixel(8'd170, 8'd85, 8'd0);
      send_pixel(8'd255, 8'd1, 8'd254);

      // Three phases of random pixels, two of them with idle gaps and receiver stalls.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 56 : 0;
         recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 24 : 0;
         for (int i = 0; i < 360; i++) send_random_pixel();
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (hsv_board.pending_hsv.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (hsv_board.errors == 0 && hsv_board.pending_hsv.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule
